// ----- hdl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms; they vanish when NO_ASSERTIONS is set.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLY(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");
`else
`define ASSERT_IMPLY(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, cond)
`endif
`endif

// ----- hdl/mis_pkg.sv -----
// ---------------------------------------------------------------------------
// Merge insertion sorter package
// Types and constants shared by the front end, command queue and back end.
// ---------------------------------------------------------------------------
package mis_pkg;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = 2;
   localparam int FIFO_CNT_W = 3;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_SORTED   = 2'd1,
      STATUS_OVERFLOW = 2'd2
   } status_type;

   typedef struct packed {
      logic signed [31:0] value;
      logic               insert;
      logic               last;
      status_type         status;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_stat_type;

   typedef enum logic {
      ST_LOAD,
      ST_DRAIN
   } back_state_type;

endpackage

// ----- hdl/mis_front.sv -----
// ---------------------------------------------------------------------------
// Merge insertion sorter front end
// Accepts values, tracks order and overflow, and issues queue commands.
// ---------------------------------------------------------------------------
module mis_front #(
   parameter int MAX_COUNT = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                busy,
   input  logic signed [31:0]  req_value,
   input  logic                req_last,
   output logic                push,
   output mis_pkg::cmd_type    push_cmd
);

   localparam int CW = $clog2(MAX_COUNT + 1);

   logic [CW-1:0]      count_ff, count_in;
   logic               ordered_ff, ordered_in;
   logic               ovf_ff, ovf_in;
   logic signed [31:0] prev_ff, prev_in;
   logic               full;
   logic               ins;
   logic               ord_next;
   logic               ovf_next;

   assign push     = start & ~busy;
   assign full     = (count_ff == CW'(MAX_COUNT));
   assign ins      = ~full;
   assign ord_next = ordered_ff & ~(ins && (count_ff != '0) && (prev_ff > req_value));
   assign ovf_next = ovf_ff | full;

   always_comb begin
      push_cmd.value  = req_value;
      push_cmd.insert = ins;
      push_cmd.last   = req_last;
      if (ovf_next) begin
         push_cmd.status = mis_pkg::STATUS_OVERFLOW;
      end else if (ord_next) begin
         push_cmd.status = mis_pkg::STATUS_SORTED;
      end else begin
         push_cmd.status = mis_pkg::STATUS_OK;
      end
   end

   always_comb begin
      count_in   = count_ff;
      ordered_in = ordered_ff;
      ovf_in     = ovf_ff;
      prev_in    = prev_ff;
      if (push) begin
         if (ins) begin
            prev_in = req_value;
         end
         if (req_last) begin
            count_in   = '0;
            ordered_in = 1'b1;
            ovf_in     = 1'b0;
         end else begin
            count_in   = count_ff + CW'(ins);
            ordered_in = ord_next;
            ovf_in     = ovf_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         ordered_ff <= 1'b1;
         ovf_ff     <= 1'b0;
      end else begin
         count_ff   <= count_in;
         ordered_ff <= ordered_in;
         ovf_ff     <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      prev_ff <= prev_in;
   end

endmodule

// ----- hdl/mis_fifo.sv -----
// ---------------------------------------------------------------------------
// Merge insertion sorter command queue
// Short first-in first-out queue between the front end and the back end.
// ---------------------------------------------------------------------------
module mis_fifo (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  mis_pkg::cmd_type        push_cmd,
   input  logic                    pop,
   output mis_pkg::cmd_type        head_cmd,
   output mis_pkg::fifo_stat_type  stat
);

   localparam int PW = mis_pkg::FIFO_PTR_W;
   localparam int NW = mis_pkg::FIFO_CNT_W;

   mis_pkg::cmd_type mem_ff [mis_pkg::FIFO_DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0]    cnt_ff, cnt_in;

   assign stat.full  = (cnt_ff == NW'(mis_pkg::FIFO_DEPTH));
   assign stat.empty = (cnt_ff == '0);
   assign head_cmd   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PW'(push);
      rd_ptr_in = rd_ptr_ff + PW'(pop);
      cnt_in    = cnt_ff + NW'(push) - NW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ----- hdl/mis_back.sv -----
// ---------------------------------------------------------------------------
// Merge insertion sorter back end
// Compare-and-shift cell row; places values, drains lists or reports status.
// ---------------------------------------------------------------------------
module mis_back #(
   parameter int MAX_COUNT = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   input  mis_pkg::cmd_type        head_cmd,
   input  mis_pkg::fifo_stat_type  stat,
   output logic                    pop,
   output logic                    rsp_strobe,
   output logic signed [31:0]      rsp_sorted_value,
   output logic [1:0]              rsp_status,
   output logic                    rsp_final_res
);

   localparam int CW = $clog2(MAX_COUNT + 1);

   mis_pkg::back_state_type state_ff, state_in;
   logic signed [31:0]      cell_ff [MAX_COUNT];
   logic signed [31:0]      cell_in [MAX_COUNT];
   logic [CW-1:0]           count_ff, count_in;
   logic [MAX_COUNT-1:0]    gt;
   logic [MAX_COUNT-1:0]    gt_below;
   logic                    strobe_ff, strobe_in;
   logic signed [31:0]      value_ff, value_in;
   mis_pkg::status_type     status_ff, status_in;
   logic                    final_ff, final_in;

   assign pop = (state_ff == mis_pkg::ST_LOAD) && !stat.empty;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mis_pkg::ST_LOAD: begin
            if (pop && head_cmd.last && (head_cmd.status == mis_pkg::STATUS_OK)) begin
               state_in = mis_pkg::ST_DRAIN;
            end
         end
         mis_pkg::ST_DRAIN: begin
            if (count_ff == CW'(1)) begin
               state_in = mis_pkg::ST_LOAD;
            end
         end
         default: state_in = mis_pkg::ST_LOAD;
      endcase
   end

   always_comb begin
      for (int i = 0; i < MAX_COUNT; i++) begin
         gt[i] = (count_ff > CW'(i)) && (cell_ff[i] > head_cmd.value);
      end
      gt_below = {gt[MAX_COUNT-2:0], 1'b0};
   end

   always_comb begin
      for (int i = 0; i < MAX_COUNT; i++) begin
         cell_in[i] = cell_ff[i];
      end
      count_in  = count_ff;
      strobe_in = 1'b0;
      value_in  = '0;
      status_in = mis_pkg::STATUS_OK;
      final_in  = 1'b0;
      unique case (state_ff)
         mis_pkg::ST_LOAD: begin
            if (pop) begin
               if (head_cmd.insert) begin
                  for (int i = 1; i < MAX_COUNT; i++) begin
                     if (gt_below[i]) begin
                        cell_in[i] = cell_ff[i-1];
                     end
                  end
                  for (int i = 0; i < MAX_COUNT; i++) begin
                     if (!gt_below[i] && (gt[i] || (count_ff == CW'(i)))) begin
                        cell_in[i] = head_cmd.value;
                     end
                  end
                  count_in = count_ff + CW'(1);
               end
               if (head_cmd.last && (head_cmd.status != mis_pkg::STATUS_OK)) begin
                  strobe_in = 1'b1;
                  status_in = head_cmd.status;
                  final_in  = 1'b1;
                  count_in  = '0;
               end
            end
         end
         mis_pkg::ST_DRAIN: begin
            for (int i = 0; i < MAX_COUNT - 1; i++) begin
               cell_in[i] = cell_ff[i+1];
            end
            strobe_in = 1'b1;
            value_in  = cell_ff[0];
            final_in  = (count_ff == CW'(1));
            count_in  = count_ff - CW'(1);
         end
         default: begin
            count_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= mis_pkg::ST_LOAD;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_COUNT; i++) begin
         cell_ff[i] <= cell_in[i];
      end
      value_ff  <= value_in;
      status_ff <= status_in;
      final_ff  <= final_in;
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_sorted_value = value_ff;
   assign rsp_status       = status_ff;
   assign rsp_final_res    = final_ff;

endmodule

// ----- hdl/merge_insertion_sorter.sv -----
// ---------------------------------------------------------------------------
// Merge insertion sorter
// Loads lists of signed values; emits each unordered list in ascending order.
// ---------------------------------------------------------------------------
// Channel    Ports                                     Transfer
// request    start, busy, req_value, req_last          start high, busy low
// response   rsp_strobe, rsp_sorted_value, rsp_status, rsp_strobe high
//            rsp_final_res
//
// A value is taken every cycle while the four-entry command queue has room.
// A list of n unordered values drains from the cell row, one result per
// cycle; an already ordered or overflowed list gives one result.
// The queue is not popped during the drain, so it can fill and raise busy.
// Reset is synchronous; the response side has no back pressure.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module merge_insertion_sorter #(
   parameter int MAX_COUNT = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic signed [31:0]  req_value,
   input  logic                req_last,
   output logic                rsp_strobe,
   output logic signed [31:0]  rsp_sorted_value,
   output logic [1:0]          rsp_status,
   output logic                rsp_final_res
);

   logic                    push;
   logic                    pop;
   mis_pkg::cmd_type        push_cmd;
   mis_pkg::cmd_type        head_cmd;
   mis_pkg::fifo_stat_type  fifo_stat;

   assign busy = fifo_stat.full;

   mis_front #(
      .MAX_COUNT (MAX_COUNT)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_value (req_value),
      .req_last  (req_last),
      .push      (push),
      .push_cmd  (push_cmd)
   );

   mis_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .stat     (fifo_stat)
   );

   mis_back #(
      .MAX_COUNT (MAX_COUNT)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .head_cmd         (head_cmd),
      .stat             (fifo_stat),
      .pop              (pop),
      .rsp_strobe       (rsp_strobe),
      .rsp_sorted_value (rsp_sorted_value),
      .rsp_status       (rsp_status),
      .rsp_final_res    (rsp_final_res)
   );

   `ASSERT_IMPLY(a_status_single, clock, reset, rsp_strobe && (rsp_status != mis_pkg::STATUS_OK) |-> rsp_final_res && (rsp_sorted_value == 32'sd0))
   `ASSERT_IMPLY(a_drain_unbroken, clock, reset, rsp_strobe && !rsp_final_res |=> rsp_strobe)
   `ASSERT_NEVER(a_full_not_empty, clock, reset, fifo_stat.full && fifo_stat.empty)

endmodule

// ----- sim/sort_checker.sv -----
// ---------------------------------------------------------------------------
// Merge insertion sorter checker
// Watches the request and response channels of the sorter and keeps its own
// ordered copy of the list being loaded. When a list closes, it queues the
// responses the sorter owes and compares each strobed response against them.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sort_checker #(
   parameter int CAPACITY = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                busy,
   input  logic signed [31:0]  req_value,
   input  logic                req_last,
   input  logic                rsp_strobe,
   input  logic signed [31:0]  rsp_sorted_value,
   input  logic [1:0]          rsp_status,
   input  logic                rsp_final_res,
   output int                  outstanding,
   output int                  failures
);

   typedef struct {
      logic signed [31:0]  sorted_value;
      mis_pkg::status_type status;
      logic                final_res;
   } sorted_result_type;

   sorted_result_type  owed_results[$];
   logic signed [31:0] held_values[$];
   logic               still_ordered = 1'b1;
   logic signed [31:0] last_taken = '0;
   logic               spilled = 1'b0;
   int                 owed_count = 0;
   int                 mismatch_count = 0;

   assign outstanding = owed_count;
   assign failures = mismatch_count;

   task automatic load_value(input logic signed [31:0] value, input logic closing);
      int                pos;
      sorted_result_type owed;
      if (held_values.size() >= CAPACITY) begin
         spilled = 1'b1;
      end else begin
         if (held_values.size() > 0 && last_taken > value) begin
            still_ordered = 1'b0;
         end
         last_taken = value;
         pos = held_values.size();
         while (pos > 0 && held_values[pos - 1] > value) begin
            pos--;
         end
         held_values.insert(pos, value);
      end
      if (closing) begin
         if (spilled || still_ordered) begin
            owed.sorted_value = '0;
            owed.status = spilled ? mis_pkg::STATUS_OVERFLOW : mis_pkg::STATUS_SORTED;
            owed.final_res = 1'b1;
            owed_results = {owed_results, owed};
         end else begin
            foreach (held_values[i]) begin
               owed.sorted_value = held_values[i];
               owed.status = mis_pkg::STATUS_OK;
               owed.final_res = (i == held_values.size() - 1);
               owed_results = {owed_results, owed};
            end
         end
         held_values.delete();
         still_ordered = 1'b1;
         spilled = 1'b0;
      end
   endtask

   task automatic compare_response();
      sorted_result_type owed;
      if (owed_results.size() == 0) begin
         $error("unexpected response: sorted_value %0d status %0d final_res %0b",
                rsp_sorted_value, rsp_status, rsp_final_res);
         mismatch_count++;
      end else begin
         owed = owed_results.pop_front();
         if (rsp_sorted_value !== owed.sorted_value) begin
            $error("sorted_value: expected %0d, actual %0d",
                   owed.sorted_value, rsp_sorted_value);
            mismatch_count++;
         end
         if (rsp_status !== owed.status) begin
            $error("status: expected %0d, actual %0d", owed.status, rsp_status);
            mismatch_count++;
         end
         if (rsp_final_res !== owed.final_res) begin
            $error("final_res: expected %0b, actual %0b", owed.final_res, rsp_final_res);
            mismatch_count++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         owed_results.delete();
         held_values.delete();
         still_ordered = 1'b1;
         spilled = 1'b0;
      end else begin
         if (rsp_strobe) begin
            compare_response();
         end
         if (start && !busy) begin
            load_value(req_value, req_last);
         end
      end
      owed_count = owed_results.size();
   end

endmodule

// ----- sim/testbench.sv -----
// ---------------------------------------------------------------------------
// Merge insertion sorter testbench
// Feeds the sorter short directed lists, then random lists of mixed shape:
// unordered, ordered, full capacity and overflowing. A checker beside the
// sorter predicts and compares every response; this module paces the
// request side in bursts and gives the verdict.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

   localparam int CAPACITY = 64;
   localparam int ITEM_TARGET = 500;
   localparam int IDLE_LIMIT = 2000;
   localparam logic signed [31:0] MOST_NEGATIVE = 32'sh8000_0000;
   localparam logic signed [31:0] MOST_POSITIVE = 32'sh7FFF_FFFF;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic signed [31:0] req_value = '0;
   logic               req_last = 1'b0;
   logic               rsp_strobe;
   logic signed [31:0] rsp_sorted_value;
   logic [1:0]         rsp_status;
   logic               rsp_final_res;
   int                 outstanding;
   int                 failures;
   int                 items_sent = 0;
   int                 burst_left = 0;
   int                 idle_cycles = 0;

   always #6 clock = ~clock;

   merge_insertion_sorter #(
      .MAX_COUNT(CAPACITY)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_value(req_value),
      .req_last(req_last),
      .rsp_strobe(rsp_strobe),
      .rsp_sorted_value(rsp_sorted_value),
      .rsp_status(rsp_status),
      .rsp_final_res(rsp_final_res)
   );

   sort_checker #(
      .CAPACITY(CAPACITY)
   ) checker_inst (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_value(req_value),
      .req_last(req_last),
      .rsp_strobe(rsp_strobe),
      .rsp_sorted_value(rsp_sorted_value),
      .rsp_status(rsp_status),
      .rsp_final_res(rsp_final_res),
      .outstanding(outstanding),
      .failures(failures)
   );

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_item(input logic signed [31:0] value, input logic closing);
      @(negedge clock);
      start <= 1'b1;
      req_value <= value;
      req_last <= closing;
      do @(posedge clock); while (busy);
      items_sent++;
   endtask

   task automatic idle_for(input int cycles);
      @(negedge clock);
      start <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   task automatic pace();
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 12);
         if ($urandom_range(0, 3) != 0) begin
            idle_for($urandom_range(1, 9));
         end
      end
      burst_left--;
   endtask

   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(0, 5))
         0: return MOST_NEGATIVE;
         1: return MOST_POSITIVE;
         2, 3: return $signed($urandom_range(0, 15)) - 8;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_list(input int length, input bit ascending);
      logic signed [31:0] value;
      longint             stepped;
      value = pick_value();
      if (ascending && value == MOST_POSITIVE && length > 1) begin
         value = $signed($urandom_range(0, 15)) - 8;
      end
      for (int i = 0; i < length; i++) begin
         if (i > 0) begin
            if (ascending) begin
               stepped = longint'(value) + (($urandom_range(0, 1) == 0)
                         ? $urandom_range(0, 3) : $urandom_range(0, 1 << 24));
               value = (stepped > longint'(MOST_POSITIVE)) ? MOST_POSITIVE
                                                            : stepped[31:0];
            end else begin
               value = pick_value();
            end
         end
         pace();
         send_item(value, i == length - 1);
      end
   endtask

   initial begin
      int choice;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      send_item(5, 1'b1);
      send_item(MOST_NEGATIVE, 1'b0);
      send_item(MOST_POSITIVE, 1'b1);
      send_item(MOST_POSITIVE, 1'b0);
      send_item(MOST_NEGATIVE, 1'b1);
      send_item(0, 1'b0);
      send_item(-1, 1'b0);
      send_item(MOST_POSITIVE, 1'b0);
      send_item(MOST_NEGATIVE, 1'b0);
      send_item(1, 1'b0);
      send_item(-1, 1'b1);
      send_item(7, 1'b0);
      send_item(7, 1'b0);
      send_item(7, 1'b1);
      send_item(3, 1'b0);
      send_item(9, 1'b0);
      send_item(3, 1'b0);
      send_item(-2, 1'b1);
      send_item(-5, 1'b0);
      send_item(-5, 1'b0);
      send_item(10, 1'b0);
      send_item(10, 1'b0);
      send_item(20, 1'b1);

      send_list(CAPACITY, 1'b0);
      send_list(CAPACITY + 2, 1'b1);
      while (items_sent < ITEM_TARGET) begin
         choice = $urandom_range(0, 99);
         if (choice < 3) begin
            send_list(CAPACITY, $urandom_range(0, 4) == 0);
         end else if (choice < 6) begin
            send_list($urandom_range(CAPACITY + 1, CAPACITY + 8), $urandom_range(0, 1));
         end else begin
            send_list($urandom_range(1, 12), $urandom_range(0, 4) == 0);
         end
      end

      @(negedge clock);
      start <= 1'b0;
      wait (outstanding == 0);
      repeat (20) @(posedge clock);
      if (failures == 0 && outstanding == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/mis_pkg.sv
hdl/mis_front.sv
hdl/mis_fifo.sv
hdl/mis_back.sv
hdl/merge_insertion_sorter.sv
sim/sort_checker.sv
sim/testbench.sv
